FILE: design/gam_pkg.sv
// Shared types, field widths and command/status codes for the graph adjacency store.
`timescale 1ns / 1ps

package gam_pkg;

  // Default capacity in nodes
  localparam int MAX_NODES_DEF = 16;

  // Fixed field widths of the command and response words
  localparam int CMD_W     = 3;
  localparam int NODE_W    = 5;
  localparam int STATUS_W  = 3;
  localparam int ROW_OUT_W = 16;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ADD_NODE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DEL_NODE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_EDGE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_EDGE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ_ROW = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_EDGE   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

  // Command word
  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } gam_cmd_t;

  // Response word
  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [NODE_W-1:0]    node_count;
    logic [ROW_OUT_W-1:0] row_bits;
  } gam_rsp_t;

endpackage

FILE: design/graph_adjacency_matrix_store_core.sv
// Add and rejected commands finish without a memory read; read row reads one row; edge insert and
// edge delete read both rows and write both back (an edge delete that finds no edge writes nothing);
// a node delete rewrites every remaining row with the deleted node's bit dropped.
// One command at a time; the next is taken the cycle after the response is registered.
// Reset clears the node count and the sequencer; the row memory is not cleared, since a row
// above the count is never read before an add writes it to zero.
`timescale 1ns / 1ps

module graph_adjacency_matrix_store_core #(
  parameter int MAX_NODES = gam_pkg::MAX_NODES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  gam_pkg::gam_cmd_t cmd,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output gam_pkg::gam_rsp_t rsp
);

  localparam int AW = $clog2(MAX_NODES);

  logic                 done_valid;
  logic                 done_ready;
  gam_pkg::gam_rsp_t    done;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [MAX_NODES-1:0] mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [MAX_NODES-1:0] mem_rdata;

  gam_ctrl #(
    .MAX_NODES (MAX_NODES)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .done_valid (done_valid),
    .done_ready (done_ready),
    .done       (done),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  gam_row_mem #(
    .DEPTH (MAX_NODES),
    .WIDTH (MAX_NODES)
  ) u_row_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output word: take a finished response when empty or being drained
  assign done_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done_valid && done_ready) begin
      rsp_valid <= 1'b1;
      rsp       <= done;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

FILE: design/gam_row_mem.sv
// Adjacency row memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module gam_row_mem #(
  parameter int DEPTH = gam_pkg::MAX_NODES_DEF,
  parameter int WIDTH = gam_pkg::MAX_NODES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write row
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read row; a read of the row being written returns the old contents
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/gam_ctrl.sv
// Command sequencer: decodes a command word, runs the read-modify-write steps on the row memory.
`timescale 1ns / 1ps

module gam_ctrl #(
  parameter int MAX_NODES = gam_pkg::MAX_NODES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_ready,
  input  gam_pkg::gam_cmd_t            cmd,
  output logic                         done_valid,
  input  logic                         done_ready,
  output gam_pkg::gam_rsp_t            done,
  output logic                         mem_we,
  output logic [$clog2(MAX_NODES)-1:0] mem_waddr,
  output logic [MAX_NODES-1:0]         mem_wdata,
  output logic                         mem_re,
  output logic [$clog2(MAX_NODES)-1:0] mem_raddr,
  input  logic [MAX_NODES-1:0]         mem_rdata
);

  localparam int AW   = $clog2(MAX_NODES);
  localparam int CW   = $clog2(MAX_NODES + 1);
  localparam int NW   = gam_pkg::NODE_W;
  localparam int CMPW = (CW > NW) ? CW : NW;
  localparam int RW   = gam_pkg::ROW_OUT_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEL  = 3'd1;
  localparam logic [2:0] S_EA   = 3'd2;
  localparam logic [2:0] S_EB   = 3'd3;
  localparam logic [2:0] S_EC   = 3'd4;
  localparam logic [2:0] S_RA   = 3'd5;
  localparam logic [2:0] S_RB   = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0]                   state;
  logic [CW-1:0]                count;
  logic [AW-1:0]                ia;
  logic [AW-1:0]                ib;
  logic                         op_clear;
  logic [CW-1:0]                ip;
  logic                         wpend;
  logic [AW-1:0]                wptr;
  logic [gam_pkg::STATUS_W-1:0] res_status;
  logic [RW-1:0]                res_row;

  logic [CMPW-1:0]      a_ext, b_ext, cnt_ext, a_m1, b_m1;
  logic                 a_ok, b_ok, full;
  logic [AW-1:0]        a_idx, b_idx;
  logic [CW-1:0]        ip_p1;
  logic [MAX_NODES-1:0] row_shift, row_drop, mask_a, mask_b, upd_a, upd_b;
  logic [RW-1:0]        row16;
  logic [NW-1:0]        cnt5;

  // Decode node numbers against the current count
  always_comb begin
    a_ext   = CMPW'(cmd.node_a);
    b_ext   = CMPW'(cmd.node_b);
    cnt_ext = CMPW'(count);
    a_ok    = (a_ext != '0) && (a_ext <= cnt_ext);
    b_ok    = (b_ext != '0) && (b_ext <= cnt_ext);
    a_m1    = a_ext - CMPW'(1);
    b_m1    = b_ext - CMPW'(1);
    a_idx   = a_m1[AW-1:0];
    b_idx   = b_m1[AW-1:0];
    full    = (count == CW'(MAX_NODES));
    ip_p1   = ip + CW'(1);
  end

  // Drop bit ia from the row being moved: bits above it slide down by one
  always_comb begin
    row_shift = mem_rdata >> 1;
    for (int i = 0; i < MAX_NODES; i++) begin
      row_drop[i] = (AW'(i) < ia) ? mem_rdata[i] : row_shift[i];
    end
  end

  // Set or clear one edge bit in each direction
  always_comb begin
    mask_b = MAX_NODES'(1) << ib;
    mask_a = MAX_NODES'(1) << ia;
    upd_a  = op_clear ? (mem_rdata & ~mask_b) : (mem_rdata | mask_b);
    upd_b  = op_clear ? (mem_rdata & ~mask_a) : (mem_rdata | mask_a);
  end

  // Narrow the row and the count to the response widths
  always_comb begin
    row16 = '0;
    for (int i = 0; i < RW && i < MAX_NODES; i++) begin
      row16[i] = mem_rdata[i];
    end
    cnt5 = '0;
    for (int i = 0; i < NW && i < CW; i++) begin
      cnt5[i] = count[i];
    end
  end

  // Drive the memory ports
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ia;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = ia;
    case (state)
      S_IDLE: begin
        // a new node starts with an empty row; its column is already clear
        if (cmd_valid && (cmd.command == gam_pkg::CMD_ADD_NODE) && !full) begin
          mem_we    = 1'b1;
          mem_waddr = count[AW-1:0];
        end
      end
      S_DEL: begin
        if (ip < count) begin
          mem_re    = 1'b1;
          mem_raddr = (ip < CW'(ia)) ? ip[AW-1:0] : ip_p1[AW-1:0];
        end
        if (wpend) begin
          mem_we    = 1'b1;
          mem_waddr = wptr;
          mem_wdata = row_drop;
        end
      end
      S_EA: begin
        mem_re = 1'b1;
      end
      S_EB: begin
        if (!op_clear || mem_rdata[ib]) begin
          mem_we    = 1'b1;
          mem_waddr = ia;
          mem_wdata = upd_a;
        end
        // with a self-loop this reads the old row, and the second write repeats the first
        mem_re    = 1'b1;
        mem_raddr = ib;
      end
      S_EC: begin
        mem_we    = 1'b1;
        mem_waddr = ib;
        mem_wdata = upd_b;
      end
      S_RA: begin
        mem_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequence the command
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      wpend <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            res_status <= gam_pkg::ST_OK;
            res_row    <= '0;
            ia         <= a_idx;
            ib         <= b_idx;
            op_clear   <= (cmd.command == gam_pkg::CMD_DEL_EDGE);
            ip         <= '0;
            wpend      <= 1'b0;
            state      <= S_FIN;
            case (cmd.command)
              gam_pkg::CMD_ADD_NODE: begin
                if (full) begin
                  res_status <= gam_pkg::ST_FULL;
                end else begin
                  count <= count + CW'(1);
                end
              end
              gam_pkg::CMD_DEL_NODE: begin
                if (count == '0) begin
                  res_status <= gam_pkg::ST_EMPTY;
                end else if (!a_ok) begin
                  res_status <= gam_pkg::ST_NOT_FOUND;
                end else begin
                  count <= count - CW'(1);
                  state <= S_DEL;
                end
              end
              gam_pkg::CMD_INS_EDGE: begin
                if (a_ok && b_ok) begin
                  state <= S_EA;
                end else begin
                  res_status <= gam_pkg::ST_INVALID;
                end
              end
              gam_pkg::CMD_DEL_EDGE: begin
                if (a_ok && b_ok) begin
                  state <= S_EA;
                end else begin
                  res_status <= gam_pkg::ST_NO_EDGE;
                end
              end
              gam_pkg::CMD_READ_ROW: begin
                if (a_ok) begin
                  state <= S_RA;
                end else begin
                  res_status <= gam_pkg::ST_INVALID;
                end
              end
              default: begin
                res_status <= gam_pkg::ST_INVALID;
              end
            endcase
          end
        end
        S_DEL: begin
          // one row read per cycle, each written back in the cycle after its read
          if (ip < count) begin
            ip    <= ip_p1;
            wptr  <= ip[AW-1:0];
            wpend <= 1'b1;
          end else begin
            wpend <= 1'b0;
          end
          if ((ip == count) && !wpend) begin
            state <= S_FIN;
          end
        end
        S_EA: begin
          state <= S_EB;
        end
        S_EB: begin
          if (op_clear && !mem_rdata[ib]) begin
            res_status <= gam_pkg::ST_NO_EDGE;
            state      <= S_FIN;
          end else begin
            state <= S_EC;
          end
        end
        S_EC: begin
          state <= S_FIN;
        end
        S_RA: begin
          state <= S_RB;
        end
        S_RB: begin
          res_row <= row16;
          state   <= S_FIN;
        end
        S_FIN: begin
          if (done_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign cmd_ready       = (state == S_IDLE);
  assign done_valid      = (state == S_FIN);
  assign done.status     = res_status;
  assign done.node_count = cnt5;
  assign done.row_bits   = res_row;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_NODES))
    else $error("node count above capacity");

  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) && !done_ready |=> (state == S_FIN) && $stable(res_status))
    else $error("result dropped while output stalled");

  a_idle_write: assert property (@(posedge clk) disable iff (rst)
    mem_we && (state == S_IDLE) |-> cmd_valid && (cmd.command == gam_pkg::CMD_ADD_NODE))
    else $error("memory write in idle without an add");

  a_add_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) && cmd_valid && (cmd.command == gam_pkg::CMD_ADD_NODE) && !full
    |=> count == $past(count) + CW'(1))
    else $error("add did not advance the node count");

  a_del_waddr: assert property (@(posedge clk) disable iff (rst)
    (state == S_DEL) && mem_we |-> CW'(mem_waddr) < count)
    else $error("row shift wrote beyond the node count");

endmodule
